### rtl/core/bnv_pkg.sv
// Shared types and constants for the bucket name validator.
`default_nettype none

package bnv_pkg;

    localparam int CHAR_W     = 8;
    localparam int LENGTH_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LENGTH_W-1:0] LONG_NAME_LIMIT = 8'd255;
    localparam logic [LENGTH_W-1:0] HOST_NAME_LIMIT = 8'd63;
    localparam logic [LENGTH_W-1:0] MIN_NAME_LENGTH = 8'd3;

    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_DASH       = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_LO   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_HI   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_LO   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_HI   = 8'h7A;

    // Register index taken from paddr[2].
    localparam logic REG_VIRTUAL_HOST_MODE = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_TOO_LONG      = 3'd1,
        ST_BAD_FIRST     = 3'd2,
        ST_BAD_CHAR      = 3'd3,
        ST_BAD_SEQ       = 3'd4,
        ST_TOO_SHORT     = 3'd5,
        ST_DOTTED_DIGITS = 3'd6
    } status_t;

endpackage

`default_nettype wire

### rtl/core/bucket_name_validator_unit.sv
// Top level of the bucket name validator: input stage, rule checks and result stage.
`default_nettype none

// The block checks a bucket name that arrives one character per request and
// returns one status request when the name ends (tlast or the empty-name flag in
// tuser). A character is taken into an input register, checked against the
// naming rules in the following cycle and, if it ends the name, its status
// is placed in the result register once that register is free, so a name
// character can be accepted in every cycle while the result register is free.
// The per-name state update is a single register loop, which sets the
// sustained rate of one character per cycle, held only by a full result stage.
// The virtual_host_mode register at byte address 0 selects the 63 character
// limit and the stricter rules; the user must write it only while no name is
// in progress, and the block itself does not enforce this.
module bucket_name_validator_unit
    import bnv_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,

    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [CHAR_W-1:0]       s_axis_tdata,   // [7:0] char_code
    input  wire                     s_axis_tlast,
    input  wire                     s_axis_tuser,   // [0] empty_name

    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [2:0] status, [7:3] zero

    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    logic                   mode_reg;

    logic                   in_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   empty_reg;

    logic [LENGTH_W-1:0]    name_length_reg, name_length_next;
    logic                   dot_seen_reg, dot_seen_next;
    logic                   non_digit_reg, non_digit_next;
    logic                   prev_dot_reg, prev_dot_next;
    logic                   prev_dash_reg, prev_dash_next;
    status_t                latched_reg, latched_next;

    logic                   out_valid_reg;
    status_t                out_status_reg;
    status_t                out_status_next;

    logic                   ends_name;
    logic                   out_free;
    logic                   advance;
    logic                   cfg_write;

    logic [LENGTH_W-1:0]    limit;
    logic                   is_alpha, is_digit, is_dot, is_dash, is_under;
    status_t                char_error;
    logic                   char_taken;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_VIRTUAL_HOST_MODE)
                       ? {{(APB_DATA_W-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == REG_VIRTUAL_HOST_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Handshake between the two stages.
    assign ends_name     = last_reg || empty_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!ends_name || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            char_reg  <= s_axis_tdata;
            last_reg  <= s_axis_tlast;
            empty_reg <= s_axis_tuser;
        end
    end

    // Character classes and the per-character rule check.
    always_comb
    begin
        limit    = mode_reg ? HOST_NAME_LIMIT : LONG_NAME_LIMIT;
        is_alpha = ((char_reg >= CHAR_UPPER_LO) && (char_reg <= CHAR_UPPER_HI))
                || ((char_reg >= CHAR_LOWER_LO) && (char_reg <= CHAR_LOWER_HI));
        is_digit = (char_reg >= CHAR_DIGIT_LO) && (char_reg <= CHAR_DIGIT_HI);
        is_dot   = (char_reg == CHAR_DOT);
        is_dash  = (char_reg == CHAR_DASH);
        is_under = (char_reg == CHAR_UNDERSCORE);

        if (name_length_reg >= limit)
        begin
            char_error = ST_TOO_LONG;
        end
        else if (is_alpha || is_digit)
        begin
            char_error = ST_OK;
        end
        else if (name_length_reg == '0)
        begin
            char_error = ST_BAD_FIRST;
        end
        else if (is_under)
        begin
            char_error = mode_reg ? ST_BAD_CHAR : ST_OK;
        end
        else if (is_dash)
        begin
            char_error = (mode_reg && prev_dot_reg) ? ST_BAD_SEQ : ST_OK;
        end
        else if (is_dot)
        begin
            char_error = (mode_reg && prev_dash_reg) ? ST_BAD_SEQ : ST_OK;
        end
        else
        begin
            char_error = ST_BAD_CHAR;
        end
    end

    always_comb
    begin
        char_taken       = !empty_reg && (latched_reg == ST_OK) && (char_error == ST_OK);
        name_length_next = name_length_reg;
        dot_seen_next    = dot_seen_reg;
        non_digit_next   = non_digit_reg;
        prev_dot_next    = prev_dot_reg;
        prev_dash_next   = prev_dash_reg;
        latched_next     = latched_reg;

        if (!empty_reg && (latched_reg == ST_OK))
        begin
            latched_next = char_error;
        end
        if (char_taken)
        begin
            name_length_next = name_length_reg + 1'b1;
            dot_seen_next    = dot_seen_reg || is_dot;
            non_digit_next   = non_digit_reg || is_alpha || is_under || is_dash;
            prev_dot_next    = is_dot;
            prev_dash_next   = is_dash;
        end

        if (latched_next != ST_OK)
        begin
            out_status_next = latched_next;
        end
        else if (name_length_next < MIN_NAME_LENGTH)
        begin
            out_status_next = ST_TOO_SHORT;
        end
        else if (dot_seen_next && !non_digit_next)
        begin
            out_status_next = ST_DOTTED_DIGITS;
        end
        else
        begin
            out_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= '0;
            dot_seen_reg    <= 1'b0;
            non_digit_reg   <= 1'b0;
            prev_dot_reg    <= 1'b0;
            prev_dash_reg   <= 1'b0;
            latched_reg     <= ST_OK;
        end
        else if (advance)
        begin
            if (ends_name)
            begin
                name_length_reg <= '0;
                dot_seen_reg    <= 1'b0;
                non_digit_reg   <= 1'b0;
                prev_dot_reg    <= 1'b0;
                prev_dash_reg   <= 1'b0;
                latched_reg     <= ST_OK;
            end
            else
            begin
                name_length_reg <= name_length_next;
                dot_seen_reg    <= dot_seen_next;
                non_digit_reg   <= non_digit_next;
                prev_dot_reg    <= prev_dot_next;
                prev_dash_reg   <= prev_dash_next;
                latched_reg     <= latched_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && ends_name;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && ends_name)
        begin
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-STATUS_W){1'b0}}, out_status_reg};

    // The state is cleared after every request that ends a name.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ends_name) |=> (name_length_reg == '0) && (latched_reg == ST_OK))
    else $error("name state not cleared after end of name");

    // Once an error is latched, the length count stops moving within the name.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((latched_reg != ST_OK) && !(advance && ends_name)) |=> $stable(name_length_reg))
    else $error("length count changed after a latched error");

    // A request that ends a name never advances while the result register is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ends_name) |-> out_free)
    else $error("result register overwritten while stalled");

    // The input side stalls only while the input register holds a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
    else $error("input stalled with an empty input register");

    // In virtual-host mode the length count never grows past the shorter limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (latched_reg == ST_OK && mode_reg && $stable(mode_reg) && $past(mode_reg))
        |-> (name_length_reg <= HOST_NAME_LIMIT) || ($past(name_length_reg) > HOST_NAME_LIMIT)
            || ($past(latched_reg) != ST_OK))
    else $error("length count grew past the virtual-host limit");

endmodule

`default_nettype wire

### tb/tb_bucket_name_validator_unit.sv
// Self-checking testbench for the bucket name validator with its own status predictor.
`default_nettype none

module tb_bucket_name_validator_unit
    import bnv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS = 10;
    localparam logic [APB_ADDR_W-1:0] HOST_MODE_ADDR = {REG_VIRTUAL_HOST_MODE, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tuser = 1'b0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    bucket_name_validator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state for the name in progress.
    bit                  host_mode = 1'b0;
    logic [LENGTH_W-1:0] name_len = '0;
    bit                  saw_dot = 1'b0;
    bit                  saw_non_digit = 1'b0;
    bit                  prev_dot = 1'b0;
    bit                  prev_dash = 1'b0;
    status_t             first_error = ST_OK;

    status_t expected_status_q[$];
    status_t next_status;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      requests_sent = 0;
    int      mismatches = 0;
    int      stall_cycles = 0;

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic status_t take_char(logic [CHAR_W-1:0] c);
        logic [LENGTH_W-1:0] limit;
        bit is_alpha;
        bit is_digit;
        bit now_dot;
        bit now_dash;
        limit = host_mode ? HOST_NAME_LIMIT : LONG_NAME_LIMIT;
        is_alpha = (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
                   (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI);
        is_digit = (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI);
        now_dot = 1'b0;
        now_dash = 1'b0;
        if (name_len >= limit)
            return ST_TOO_LONG;
        if (is_alpha)
            saw_non_digit = 1'b1;
        else if (is_digit)
            saw_non_digit = saw_non_digit;
        else if (name_len == 0)
            return ST_BAD_FIRST;
        else if (c == CHAR_UNDERSCORE)
        begin
            if (host_mode)
                return ST_BAD_CHAR;
            saw_non_digit = 1'b1;
        end
        else if (c == CHAR_DASH)
        begin
            if (host_mode && prev_dot)
                return ST_BAD_SEQ;
            saw_non_digit = 1'b1;
            now_dash = 1'b1;
        end
        else if (c == CHAR_DOT)
        begin
            if (host_mode && prev_dash)
                return ST_BAD_SEQ;
            saw_dot = 1'b1;
            now_dot = 1'b1;
        end
        else
            return ST_BAD_CHAR;
        name_len = name_len + 1'b1;
        prev_dot = now_dot;
        prev_dash = now_dash;
        return ST_OK;
    endfunction

    function automatic void predict_status(logic [CHAR_W-1:0] c, bit last, bit empty);
        status_t verdict;
        if (!empty && first_error == ST_OK)
            first_error = take_char(c);
        if (last || empty)
        begin
            if (first_error != ST_OK)
                verdict = first_error;
            else if (name_len < MIN_NAME_LENGTH)
                verdict = ST_TOO_SHORT;
            else if (saw_dot && !saw_non_digit)
                verdict = ST_DOTTED_DIGITS;
            else
                verdict = ST_OK;
            expected_status_q.push_back(verdict);
            name_len = '0;
            saw_dot = 1'b0;
            saw_non_digit = 1'b0;
            prev_dot = 1'b0;
            prev_dash = 1'b0;
            first_error = ST_OK;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_status_q.size() == 0)
                note_failure($sformatf("status request with no name pending, tdata %0h",
                                       m_axis_tdata));
            else
            begin
                next_status = expected_status_q.pop_front();
                if (m_axis_tdata !== {{(OUT_DATA_W-STATUS_W){1'b0}}, next_status})
                    note_failure($sformatf("status expected %s (%0h) got tdata %0h",
                                           next_status.name(), next_status, m_axis_tdata));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stall_cycles <= 0;
        else if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_request(logic [CHAR_W-1:0] code, bit last, bit empty);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= CHAR_W'($urandom);
            s_axis_tlast <= 1'($urandom);
            s_axis_tuser <= 1'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= code;
        s_axis_tlast <= last;
        s_axis_tuser <= empty;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_status(code, last, empty);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_request(txt[i], i == txt.len() - 1, 1'b0);
    endtask

    task automatic send_filled(int count, logic [CHAR_W-1:0] code);
        for (int i = 0; i < count; i++)
            send_request(code, i == count - 1, 1'b0);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_host_mode(bit mode);
        drain_pipeline();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= HOST_MODE_ADDR;
        pwdata <= {{(APB_DATA_W-1){1'b0}}, mode};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        host_mode = mode;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_first_characters();
        set_host_mode(1'b0);
        send_text(".ab");
        send_text("-ab");
        send_text("_ab");
        send_request(8'h00, 1'b0, 1'b0);
        send_text("ab");
        send_request(8'hFF, 1'b0, 1'b0);
        send_text("ab");
        send_text("Zz9");
        send_text("9az");
    endtask

    task automatic test_character_rules();
        set_host_mode(1'b0);
        send_text("a_b");
        send_text("a$b");
        send_request("a", 1'b0, 1'b0);
        send_request(8'h80, 1'b0, 1'b0);
        send_text("b");
        set_host_mode(1'b1);
        send_text("a_b");
        send_text("AZaz09");
    endtask

    task automatic test_sequence_rules();
        set_host_mode(1'b0);
        send_text("a.-b");
        send_text("a-.b");
        set_host_mode(1'b1);
        send_text("a.-b");
        send_text("a-.b");
        send_text("a-b.c");
        send_text("a..b--c");
    endtask

    task automatic test_end_of_name_verdicts();
        set_host_mode(1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        send_text("ab");
        send_text("abc");
        send_text("1.2");
        send_text("123");
        send_text("1.2.a");
        send_request("a", 1'b0, 1'b0);
        send_request("b", 1'b0, 1'b0);
        send_request("c", 1'b0, 1'b1);
        send_request("a", 1'b0, 1'b0);
        send_request("b", 1'b0, 1'b0);
        send_request("c", 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
        send_text("a$xyz.-_");
    endtask

    task automatic test_length_limits();
        set_host_mode(1'b1);
        send_filled(int'(HOST_NAME_LIMIT) + 1, "b");
        set_host_mode(1'b0);
        send_filled(int'(LONG_NAME_LIMIT) + 1, "z");
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(int pos);
        int r;
        r = $urandom_range(99);
        if (pos == 0 && r < 90)
            r = r % 65;
        if (r < 30)
            return CHAR_LOWER_LO + CHAR_W'($urandom_range(25));
        else if (r < 45)
            return CHAR_UPPER_LO + CHAR_W'($urandom_range(25));
        else if (r < 65)
            return CHAR_DIGIT_LO + CHAR_W'($urandom_range(9));
        else if (r < 77)
            return CHAR_DOT;
        else if (r < 87)
            return CHAR_DASH;
        else if (r < 92)
            return CHAR_UNDERSCORE;
        else
            return CHAR_W'($urandom_range(255));
    endfunction

    task automatic test_random_traffic(int src_pct, int sink_pct, bit mode, int goal);
        int start;
        int len;
        int kind;
        bit digits_only;
        bit end_by_empty;
        logic [CHAR_W-1:0] c;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        set_host_mode(mode);
        start = requests_sent;
        while (requests_sent - start < goal)
        begin
            kind = $urandom_range(99);
            if (kind < 5)
                len = 0;
            else
                len = $urandom_range(1, 24);
            digits_only = ($urandom_range(5) == 0);
            end_by_empty = ($urandom_range(19) == 0);
            if (len == 0)
                send_request(CHAR_W'($urandom), 1'($urandom), 1'b1);
            for (int i = 0; i < len; i++)
            begin
                if (digits_only)
                    c = (i > 0 && $urandom_range(3) == 0) ? CHAR_DOT
                                                           : CHAR_DIGIT_LO + CHAR_W'($urandom_range(9));
                else
                    c = pick_char(i);
                send_request(c, (i == len - 1) && !end_by_empty, 1'b0);
            end
            if (len != 0 && end_by_empty)
                send_request(CHAR_W'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_idle_pct = 21;
        sink_idle_pct = 62;
        test_first_characters();
        test_character_rules();
        test_sequence_rules();
        test_end_of_name_verdicts();
        test_length_limits();
        test_random_traffic(62, 21, 1'b1, 20);
        test_random_traffic(0, 0, 1'b0, 20);
        drain_pipeline();
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
